@@ hw/rtl/eg_pkg.sv @@
package eg_pkg;

  // bits of the radicand consumed by one square root cell
  localparam int unsigned SqrtDigitBits = 2;

  // width rounded up to whole bytes
  function automatic int unsigned byte_round(input int unsigned bits);
    byte_round = ((bits + 7) / 8) * 8;
  endfunction

endpackage

@@ hw/rtl/edge_geometry.sv @@
// channel   dir  tdata fields (low bit up)                         tuser
// s_axis    in   x_start, y_start, x_end, y_end                    -
// m_axis    out  mid_x, mid_y, edge_length, normal_x, normal_y     degenerate
//
// one request per cycle sustained unless m_axis stalls; every stage is registered
// data passes stages 0 to 2, the square root cells, the divide cells and the output
// register; a root cell yields one root bit, a divide cell one quotient bit
// rst_ni clears every valid flag at once; payload registers are not reset
// a stalled m_axis fills the chain from the output back; s_axis_tready
// stays high while any cell is empty
module edge_geometry #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // x_start, y_start, x_end, y_end
  input  logic [eg_pkg::byte_round(4*COORD_BITS)-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // mid_x, mid_y, edge_length, normal_x, normal_y
  output logic [eg_pkg::byte_round(3*COORD_BITS+2*FRAC_BITS+5)-1:0] m_axis_tdata,
  // degenerate
  output logic m_axis_tuser
);
  import eg_pkg::*;

  localparam int unsigned CB       = COORD_BITS;
  localparam int unsigned LW       = CB + 1;
  localparam int unsigned RAD_W    = 2 * LW;
  localparam int unsigned RW       = LW + 3;
  localparam int unsigned DW       = CB + 2;
  localparam int unsigned QW       = FRAC_BITS + 1;
  localparam int unsigned NW       = FRAC_BITS + 2;
  localparam int unsigned SQ_SIDE  = 4 * CB + 2;
  localparam int unsigned DV_SIDE  = 2 * CB + 2;
  localparam int unsigned NDIV     = FRAC_BITS + 1;
  localparam int unsigned OUT_W    = byte_round(3*CB + 2*FRAC_BITS + 5);

  // input fields
  logic [CB-1:0] xs, ys, xe, ye;
  assign xs = s_axis_tdata[0*CB +: CB];
  assign ys = s_axis_tdata[1*CB +: CB];
  assign xe = s_axis_tdata[2*CB +: CB];
  assign ye = s_axis_tdata[3*CB +: CB];

  // stage 0: midpoint, differences and magnitudes
  logic          v0_q, r0;
  logic [CB:0]   sum_x, sum_y, dx, dy;
  logic [CB-1:0] mid_x_q, mid_y_q, adx_q, ady_q;
  logic          neg_x_q, neg_y_q;

  always_comb begin
    sum_x = {xs[CB-1], xs} + {xe[CB-1], xe};
    sum_y = {ys[CB-1], ys} + {ye[CB-1], ye};
    dx    = {xe[CB-1], xe} - {xs[CB-1], xs};
    dy    = {ye[CB-1], ye} - {ys[CB-1], ys};
  end

  // stage 1: squares
  logic            v1_q, r1;
  logic [2*CB-1:0] sqx_q, sqy_q;
  logic [CB-1:0]   mid_x1_q, mid_y1_q, adx1_q, ady1_q;
  logic            neg_x1_q, neg_y1_q;

  // stage 2: sum of squares
  logic              v2_q, r2;
  logic [RAD_W-1:0]  rad2_q;
  logic [SQ_SIDE-1:0] side2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s_axis_tready) v0_q <= s_axis_tvalid;
      if (r0)            v1_q <= v0_q;
      if (r1)            v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mid_x_q <= sum_x[CB:1];
      mid_y_q <= sum_y[CB:1];
      adx_q   <= dx[CB] ? CB'(-dx) : dx[CB-1:0];
      ady_q   <= dy[CB] ? CB'(-dy) : dy[CB-1:0];
      neg_x_q <= !dy[CB];
      neg_y_q <= dx[CB];
    end
    if (r0 && v0_q) begin
      sqx_q    <= adx_q * adx_q;
      sqy_q    <= ady_q * ady_q;
      mid_x1_q <= mid_x_q;
      mid_y1_q <= mid_y_q;
      adx1_q   <= adx_q;
      ady1_q   <= ady_q;
      neg_x1_q <= neg_x_q;
      neg_y1_q <= neg_y_q;
    end
    if (r1 && v1_q) begin
      rad2_q  <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
      side2_q <= {neg_y1_q, neg_x1_q, ady1_q, adx1_q, mid_y1_q, mid_x1_q};
    end
  end

  // square root chain, one root bit per cell
  logic                sq_v   [LW+1];
  logic                sq_rdy [LW+1];
  logic [RW-1:0]       sq_rem [LW+1];
  logic [LW-1:0]       sq_root[LW+1];
  logic [RAD_W-1:0]    sq_rad [LW+1];
  logic [SQ_SIDE-1:0]  sq_side[LW+1];

  // front stage readiness follows the first root cell
  assign r2 = sq_rdy[0];
  assign r1 = !v2_q || r2;
  assign r0 = !v1_q || r1;
  assign s_axis_tready = !v0_q || r0;

  assign sq_v[0]    = v2_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = rad2_q;
  assign sq_side[0] = side2_q;

  for (genvar i = 0; i < LW; i++) begin : g_sqrt
    eg_sqrt_cell #(.LW(LW), .RAD_W(RAD_W), .RW(RW), .SIDE_W(SQ_SIDE)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(sq_v[i]),     .ready_o(sq_rdy[i]),
      .rem_i(sq_rem[i]),     .root_i(sq_root[i]),
      .rad_i(sq_rad[i]),     .side_i(sq_side[i]),
      .valid_o(sq_v[i+1]),   .ready_i(sq_rdy[i+1]),
      .rem_o(sq_rem[i+1]),   .root_o(sq_root[i+1]),
      .rad_o(sq_rad[i+1]),   .side_o(sq_side[i+1])
    );
  end

  // divide chain, one quotient bit per cell for both normal components
  logic               dv_v   [NDIV+1];
  logic               dv_rdy [NDIV+1];
  logic [LW-1:0]      dv_len [NDIV+1];
  logic [DW-1:0]      dv_rx  [NDIV+1];
  logic [DW-1:0]      dv_ry  [NDIV+1];
  logic [QW-1:0]      dv_qx  [NDIV+1];
  logic [QW-1:0]      dv_qy  [NDIV+1];
  logic [DV_SIDE-1:0] dv_side[NDIV+1];

  // normal_x = -dy / len takes |dy|, normal_y = dx / len takes |dx|
  assign dv_v[0]      = sq_v[LW];
  assign sq_rdy[LW]   = dv_rdy[0];
  assign dv_len[0]    = sq_root[LW];
  assign dv_rx[0]     = DW'(sq_side[LW][3*CB +: CB]);
  assign dv_ry[0]     = DW'(sq_side[LW][2*CB +: CB]);
  assign dv_qx[0]     = '0;
  assign dv_qy[0]     = '0;
  assign dv_side[0]   = {sq_side[LW][4*CB +: 2], sq_side[LW][0 +: 2*CB]};

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    eg_div_cell #(.LW(LW), .DW(DW), .QW(QW), .SIDE_W(DV_SIDE)) u_cell (
      .clk_i, .rst_ni,
      .valid_i(dv_v[j]),    .ready_o(dv_rdy[j]),
      .len_i(dv_len[j]),
      .rem_x_i(dv_rx[j]),   .rem_y_i(dv_ry[j]),
      .q_x_i(dv_qx[j]),     .q_y_i(dv_qy[j]),
      .side_i(dv_side[j]),
      .valid_o(dv_v[j+1]),  .ready_i(dv_rdy[j+1]),
      .len_o(dv_len[j+1]),
      .rem_x_o(dv_rx[j+1]), .rem_y_o(dv_ry[j+1]),
      .q_x_o(dv_qx[j+1]),   .q_y_o(dv_qy[j+1]),
      .side_o(dv_side[j+1])
    );
  end

  // output register: signs, degenerate edge
  logic          out_v_q;
  logic [CB-1:0] o_mid_x_q, o_mid_y_q;
  logic [LW-1:0] o_len_q;
  logic [NW-1:0] o_nx_q, o_ny_q, nx_d, ny_d;
  logic          o_deg_q, deg_d;

  assign dv_rdy[NDIV] = !out_v_q || m_axis_tready;

  always_comb begin
    deg_d = dv_len[NDIV] == '0;
    nx_d  = dv_side[NDIV][2*CB]   ? NW'(-NW'(dv_qx[NDIV])) : NW'(dv_qx[NDIV]);
    ny_d  = dv_side[NDIV][2*CB+1] ? NW'(-NW'(dv_qy[NDIV])) : NW'(dv_qy[NDIV]);
    if (deg_d) begin
      nx_d = '0;
      ny_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (dv_rdy[NDIV]) begin
      out_v_q <= dv_v[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_rdy[NDIV] && dv_v[NDIV]) begin
      o_mid_x_q <= dv_side[NDIV][0 +: CB];
      o_mid_y_q <= dv_side[NDIV][CB +: CB];
      o_len_q   <= dv_len[NDIV];
      o_nx_q    <= nx_d;
      o_ny_q    <= ny_d;
      o_deg_q   <= deg_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'({o_ny_q, o_nx_q, o_len_q, o_mid_y_q, o_mid_x_q});
  assign m_axis_tuser  = o_deg_q;

`ifndef ASSERT_OFF
  // degenerate flag matches a zero length
  a_deg_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (o_len_q == '0)))
    else $error("degenerate flag does not match length");

  // degenerate result carries a zero normal
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (o_nx_q == '0 && o_ny_q == '0))
    else $error("degenerate edge with nonzero normal");

  // input backs up only when the whole chain is full and the output stalls
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the chain has room");

  // quotients never exceed one in Q1.FRAC
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_v[NDIV] && !deg_d) |->
      (dv_qx[NDIV] <= QW'(1) << FRAC_BITS && dv_qy[NDIV] <= QW'(1) << FRAC_BITS))
    else $error("normal component out of range");
`endif

endmodule

@@ hw/rtl/eg_sqrt_cell.sv @@
module eg_sqrt_cell #(
  parameter int unsigned LW     = 25,
  parameter int unsigned RAD_W  = 50,
  parameter int unsigned RW     = 28,
  parameter int unsigned SIDE_W = 98
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [RW-1:0]     rem_i,
  input  logic [LW-1:0]     root_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [RW-1:0]     rem_o,
  output logic [LW-1:0]     root_o,
  output logic [RAD_W-1:0]  rad_o,
  output logic [SIDE_W-1:0] side_o
);
  import eg_pkg::*;

  logic              valid_q;
  logic [RW-1:0]     rem_q, rem_d, rem_cat, trial;
  logic [LW-1:0]     root_q, root_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [SIDE_W-1:0] side_q;
  logic              take;

  // one root bit: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    rem_cat = {rem_i[RW-SqrtDigitBits-1:0], rad_i[RAD_W-1 -: SqrtDigitBits]};
    trial   = RW'({root_i, 2'b01});
    take    = rem_cat >= trial;
    rem_d   = take ? rem_cat - trial : rem_cat;
    root_d  = (root_i << 1) | LW'(take);
    rad_d   = rad_i << SqrtDigitBits;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

@@ hw/rtl/eg_div_cell.sv @@
module eg_div_cell #(
  parameter int unsigned LW     = 25,
  parameter int unsigned DW     = 26,
  parameter int unsigned QW     = 17,
  parameter int unsigned SIDE_W = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [LW-1:0]     len_i,
  input  logic [DW-1:0]     rem_x_i,
  input  logic [DW-1:0]     rem_y_i,
  input  logic [QW-1:0]     q_x_i,
  input  logic [QW-1:0]     q_y_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [LW-1:0]     len_o,
  output logic [DW-1:0]     rem_x_o,
  output logic [DW-1:0]     rem_y_o,
  output logic [QW-1:0]     q_x_o,
  output logic [QW-1:0]     q_y_o,
  output logic [SIDE_W-1:0] side_o
);
  import eg_pkg::*;

  logic              valid_q;
  logic [LW-1:0]     len_q;
  logic [DW-1:0]     rem_x_q, rem_y_q, rem_x_d, rem_y_d, len_ext, rx, ry;
  logic [QW-1:0]     q_x_q, q_y_q, q_x_d, q_y_d;
  logic [SIDE_W-1:0] side_q;
  logic              ge_x, ge_y;

  // one quotient bit for each of the two divides sharing the divisor
  always_comb begin
    len_ext = DW'(len_i);
    ge_x    = rem_x_i >= len_ext;
    ge_y    = rem_y_i >= len_ext;
    rx      = ge_x ? rem_x_i - len_ext : rem_x_i;
    ry      = ge_y ? rem_y_i - len_ext : rem_y_i;
    rem_x_d = rx << 1;
    rem_y_d = ry << 1;
    q_x_d   = (q_x_i << 1) | QW'(ge_x);
    q_y_d   = (q_y_i << 1) | QW'(ge_y);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      len_q   <= len_i;
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      q_x_q   <= q_x_d;
      q_y_q   <= q_y_d;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign len_o   = len_q;
  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;
  assign q_x_o   = q_x_q;
  assign q_y_o   = q_y_q;
  assign side_o  = side_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CoordBits = 24;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned InW  = eg_pkg::byte_round(4*CoordBits);
  localparam int unsigned OutW = eg_pkg::byte_round(3*CoordBits+2*FracBits+5);
  localparam int unsigned Latency = 46;

  typedef struct packed {
    logic                  degenerate;
    logic [FracBits+1:0]   normal_y;
    logic [FracBits+1:0]   normal_x;
    logic [CoordBits:0]    edge_length;
    logic [CoordBits-1:0]  mid_y;
    logic [CoordBits-1:0]  mid_x;
  } geom_t;

  // expected edge results and mismatch bookkeeping
  class geom_scoreboard;
    geom_t pending[$];
    int    errors;
    int    checked;

    // floor integer square root of a wide value
    function automatic logic [CoordBits:0] isqrt(input logic [67:0] v);
      logic [67:0] root;
      logic [67:0] cand;
      root = '0;
      for (int b = CoordBits; b >= 0; b--) begin
        cand = root | (68'd1 << b);
        if (cand * cand <= v) root = cand;
      end
      return root[CoordBits:0];
    endfunction

    // signed value scaled by 2^FracBits over length, toward zero
    function automatic logic [FracBits+1:0] ratio(input longint num, input longint len);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag << FracBits) / len;
      if (num < 0) q = -q;
      return q[FracBits+1:0];
    endfunction

    function void note_edge(input logic [InW-1:0] data);
      logic signed [CoordBits-1:0] xs, ys, xe, ye;
      longint dx, dy, sx, sy;
      logic [67:0] sq;
      geom_t g;
      xs = data[CoordBits-1:0];
      ys = data[2*CoordBits-1:CoordBits];
      xe = data[3*CoordBits-1:2*CoordBits];
      ye = data[4*CoordBits-1:3*CoordBits];
      dx = longint'(xe) - longint'(xs);
      dy = longint'(ye) - longint'(ys);
      sx = longint'(xs) + longint'(xe);
      sy = longint'(ys) + longint'(ye);
      g.mid_x = CoordBits'(sx >>> 1);
      g.mid_y = CoordBits'(sy >>> 1);
      sq = 68'(dx * dx) + 68'(dy * dy);
      g.edge_length = isqrt(sq);
      if (g.edge_length == 0) begin
        g.normal_x = '0;
        g.normal_y = '0;
        g.degenerate = 1'b1;
      end else begin
        g.normal_x = ratio(-dy, longint'(g.edge_length));
        g.normal_y = ratio(dx, longint'(g.edge_length));
        g.degenerate = 1'b0;
      end
      pending = {pending, g};
    endfunction

    function void check_result(input logic [OutW-1:0] data, input logic user);
      geom_t got;
      geom_t exp_g;
      got = {user, data[3*CoordBits+2*FracBits+4:0]};
      checked++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_g = pending.pop_front();
      if (got !== exp_g) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp mx=%h my=%h len=%h nx=%h ny=%h dg=%b",
                   exp_g.mid_x, exp_g.mid_y, exp_g.edge_length, exp_g.normal_x,
                   exp_g.normal_y, exp_g.degenerate);
          $display("          got mx=%h my=%h len=%h nx=%h ny=%h dg=%b",
                   got.mid_x, got.mid_y, got.edge_length, got.normal_x,
                   got.normal_y, got.degenerate);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  geom_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off;
  int sent;

  edge_geometry uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result sampling
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(m_axis_tdata, m_axis_tuser);
  end

  // receiver readiness, changed at falling edge
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // send one edge request, with random leading gaps
  task automatic send_edge(input logic [23:0] xs, ys, xe, ye);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ye, yx_dummy(ys), xe, xs} ;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_edge(s_axis_tdata);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] yx_dummy(input logic [23:0] v);
    return v;
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'(24'h800000 + $urandom_range(15));
      1: return 24'(24'h7FFFFF - $urandom_range(15));
      2: return 24'($urandom_range(255) - 128);
      default: return 24'($urandom());
    endcase
  endfunction

  // random edge: mix of axis-aligned, degenerate, short and arbitrary
  task automatic send_random();
    logic [23:0] xs, ys, xe, ye;
    xs = rand_coord();
    ys = rand_coord();
    xe = rand_coord();
    ye = rand_coord();
    case ($urandom_range(9))
      0: begin xe = xs; ye = ys; end
      1: ye = ys;
      2: xe = xs;
      3: begin
        xe = 24'(xs + $urandom_range(7) - 3);
        ye = 24'(ys + $urandom_range(7) - 3);
      end
      default: ;
    endcase
    send_edge(xs, ys, xe, ye);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    while (n < Latency + 10) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  initial begin
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b0;
    sent = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corners: extremes, zero length, axis-aligned, sign edges
    send_edge(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    send_edge(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000);
    send_edge(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    send_edge(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF);
    send_edge(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    send_edge(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_edge(24'h000000, 24'h000000, 24'h010000, 24'h000000);
    send_edge(24'h000000, 24'h000000, 24'hFF0000, 24'h000000);
    send_edge(24'h000000, 24'h000000, 24'h000000, 24'h010000);
    send_edge(24'h000000, 24'h000000, 24'h000000, 24'hFF0000);
    send_edge(24'h000000, 24'h000000, 24'h000001, 24'h000000);
    send_edge(24'h000000, 24'h000000, 24'h000001, 24'h000001);
    send_edge(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000);
    send_edge(24'h000001, 24'h000000, 24'h000000, 24'h000001);
    send_edge(24'h800000, 24'h000000, 24'h7FFFFF, 24'h000000);
    send_edge(24'h000000, 24'h800000, 24'h000000, 24'h7FFFFF);
    send_edge(24'h123456, 24'hABCDEF, 24'h654321, 24'hFEDCBA);
    send_edge(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h000001);
    send_edge(24'h030000, 24'h040000, 24'h000000, 24'h000000);

    // sender idles lightly, receiver heavily
    send_idle_pct = 8;
    recv_idle_pct = 80;
    repeat (420) send_random();

    // long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    fork
      begin
        int c;
        c = 0;
        while (c < 200) begin
          @(posedge clk_i);
          c++;
        end
        hold_off = 1'b0;
      end
      repeat (80) send_random();
    join

    send_idle_pct = 80;
    recv_idle_pct = 8;
    repeat (380) send_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (420) send_random();
    s_axis_tvalid <= 1'b0;

    drain();
    $display("edges sent %0d, results checked %0d, under mixed idling and a long output stall",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d left over", board.errors, board.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
